### rtl/h2hv_pkg.sv
// Package for the HTTP/2 header block validator.
// Holds operation codes, mask bits, field classes and name-match tables; no dependencies.
package h2hv_pkg;

  localparam int SlotsDefault = 16;
  localparam int MaxValueLenDefault = 8192;

  localparam logic [1:0] OP_NAME = 2'd0;
  localparam logic [1:0] OP_VALUE = 2'd1;
  localparam logic [1:0] OP_EOF = 2'd2;
  localparam logic [1:0] OP_EOB = 2'd3;

  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_REGULAR = 3'd1;
  localparam logic [2:0] CLS_METHOD = 3'd2;
  localparam logic [2:0] CLS_SCHEME = 3'd3;
  localparam logic [2:0] CLS_PATH = 3'd4;
  localparam logic [2:0] CLS_AUTHORITY = 3'd5;
  localparam logic [2:0] CLS_PROTOCOL = 3'd6;

  localparam int B_METHOD = 0;
  localparam int B_SCHEME = 1;
  localparam int B_PATH = 2;
  localparam int B_AUTH = 3;
  localparam int B_PROTO = 4;
  localparam int B_REGULAR = 5;
  localparam int B_BAD = 6;

  localparam int CandCount = 12;
  localparam int C_CONNECTION = 0;
  localparam int C_PROXY = 1;
  localparam int C_KEEPALIVE = 2;
  localparam int C_TRANSFER = 3;
  localparam int C_UPGRADE = 4;
  localparam int C_TE = 5;
  localparam int C_CLEN = 6;
  localparam int C_METHOD = 7;
  localparam int C_SCHEME = 8;
  localparam int C_PATH = 9;
  localparam int C_AUTHORITY = 10;
  localparam int C_PROTOCOL = 11;

  localparam logic [4:0] NameLenMax = 5'd31;

  typedef logic [6:0] mask_t;

  typedef struct packed {
    logic [4:0] name_length;
    logic [CandCount-1:0] cands;
    logic name_bad;
    logic colon;
    logic value_empty;
    logic value_is8;
    logic value_bad;
    logic last_blank;
    logic trailers;
    logic [13:0] path_len;
    logic question;
    logic [31:0] digits;
  } field_sum_t;

  localparam logic [255:0] TokenMap = {128'h0, 32'h57FFFFFF, 32'hC0000000,
                                       32'h03FF6CFA, 32'h0};

  function automatic logic [4:0] cand_len(input int c);
    case (c)
      0: cand_len = 5'd10;
      1: cand_len = 5'd16;
      2: cand_len = 5'd10;
      3: cand_len = 5'd17;
      4: cand_len = 5'd7;
      5: cand_len = 5'd2;
      6: cand_len = 5'd14;
      7: cand_len = 5'd7;
      8: cand_len = 5'd7;
      9: cand_len = 5'd5;
      10: cand_len = 5'd10;
      default: cand_len = 5'd9;
    endcase
  endfunction

  function automatic logic [7:0] cand_char(input int c, input logic [4:0] i);
    logic [8*17-1:0] s;
    s = '0;
    case (c)
      0: s = 136'("connection");
      1: s = 136'("proxy-connection");
      2: s = 136'("keep-alive");
      3: s = 136'("transfer-encoding");
      4: s = 136'("upgrade");
      5: s = 136'("te");
      6: s = 136'("content-length");
      7: s = 136'(":method");
      8: s = 136'(":scheme");
      9: s = 136'(":path");
      10: s = 136'(":authority");
      default: s = 136'(":protocol");
    endcase
    if (i < cand_len(c))
      cand_char = s[8*(int'(cand_len(c)) - 1 - int'(i)) +: 8];
    else
      cand_char = 8'h00;
  endfunction

  function automatic logic [7:0] trailers_char(input logic [2:0] i);
    logic [63:0] s;
    s = "trailers";
    trailers_char = s[8*(7 - int'(i)) +: 8];
  endfunction

endpackage

### rtl/http2_header_block_validator_top.sv
// Top level of the HTTP/2 request header block validator.
// Depends on h2hv_pkg and h2hv_field_scan; holds the per-slot mask memory.
//
//   channel  dir  tdata                                   tuser
//   s_axis   in   [7:0] data_byte                         [1:0] op, [5:2] slot
//   m_axis   out  see port comment                        [0] result_kind
//
// One transaction per cycle while s_axis_tready is high. An end marker reads its slot mask
// into a register when it is accepted and writes the mask back with its result when it leaves
// that register stage; a same-slot marker that follows is forwarded.
// Reset clears the mask memory through one valid bit per entry.
// The output register holds a result while m_axis_tready is low; input stalls only while
// a second result waits behind it.
module http2_header_block_validator_top import h2hv_pkg::*; #(
  parameter int SLOTS = SlotsDefault,
  parameter int MAX_VALUE_LEN = MaxValueLenDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic [5:0] s_axis_tuser,   // [1:0] op, [5:2] slot
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [3:0] slot_out, [6:4] field_class, [7] block_condemned, [21:8] path_length,
  // [22] query_present, [54:23] body_len, [55] body_len_valid,
  // [56] accepted, [57] missing_required, [63:58] zero
  output logic [63:0] m_axis_tdata,
  output logic [0:0] m_axis_tuser    // [0] result_kind
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [1:0] op;
  logic [3:0] slot_in;
  logic [3:0] slot_fold;
  logic [3:0] fold_lut [16];
  logic [SW-1:0] sidx;
  logic take;
  field_sum_t summary;

  assign op = s_axis_tuser[1:0];
  assign slot_in = s_axis_tuser[5:2];

  for (genvar g = 0; g < 16; g++) begin : g_fold
    assign fold_lut[g] = 4'(g % SLOTS);
  end

  assign slot_fold = fold_lut[slot_in];
  assign sidx = SW'(slot_fold);

  mask_t mem [SLOTS];
  logic [SLOTS-1:0] mem_valid;
  mask_t rd_data;

  logic p_valid, p_eob;
  logic [SW-1:0] p_idx;
  logic [3:0] p_slot;
  field_sum_t p_sum;

  logic out_free;
  logic p_adv;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign p_adv = p_valid && out_free;
  assign s_axis_tready = !(p_valid && !out_free);
  assign take = s_axis_tvalid && s_axis_tready;

  h2hv_field_scan #(.MAX_VALUE_LEN(MAX_VALUE_LEN)) u_scan (
    .clk(clk), .rst(rst), .take(take), .op(op), .data_byte(s_axis_tdata),
    .summary(summary)
  );

  mask_t m_cur, m_new;
  logic [2:0] cls;
  logic [13:0] plen;
  logic qp, clv;
  logic [31:0] clen;

  function automatic logic isn(field_sum_t s, int c);
    isn = s.cands[c] && s.name_length == cand_len(c);
  endfunction

  always_comb begin
    logic [4:0] bit_sel;
    m_cur = rd_data;
    m_new = m_cur;
    cls = CLS_NONE;
    plen = '0;
    qp = 1'b0;
    clv = 1'b0;
    clen = '0;
    bit_sel = '0;
    if (p_eob) begin
      m_new = '0;
    end else if (!m_cur[B_BAD]) begin
      if (p_sum.name_length == '0 || p_sum.name_bad || p_sum.value_bad || p_sum.last_blank) begin
        m_new[B_BAD] = 1'b1;
      end else if (p_sum.colon) begin
        if (isn(p_sum, C_METHOD)) bit_sel[B_METHOD] = 1'b1;
        else if (isn(p_sum, C_SCHEME)) bit_sel[B_SCHEME] = 1'b1;
        else if (isn(p_sum, C_PATH)) bit_sel[B_PATH] = 1'b1;
        else if (isn(p_sum, C_AUTHORITY)) bit_sel[B_AUTH] = 1'b1;
        else if (isn(p_sum, C_PROTOCOL)) bit_sel[B_PROTO] = 1'b1;
        if (bit_sel == '0 || (m_cur[4:0] & bit_sel) != '0 || m_cur[B_REGULAR]) begin
          m_new[B_BAD] = 1'b1;
        end else begin
          m_new[4:0] = m_cur[4:0] | bit_sel;
          if (bit_sel[B_PATH] && p_sum.value_empty) begin
            m_new[B_BAD] = 1'b1;
          end else begin
            if (bit_sel[B_METHOD]) cls = CLS_METHOD;
            else if (bit_sel[B_SCHEME]) cls = CLS_SCHEME;
            else if (bit_sel[B_PATH]) cls = CLS_PATH;
            else if (bit_sel[B_AUTH]) cls = CLS_AUTHORITY;
            else cls = CLS_PROTOCOL;
            if (bit_sel[B_PATH]) begin
              plen = p_sum.path_len;
              qp = p_sum.question;
            end
          end
        end
      end else begin
        m_new[B_REGULAR] = 1'b1;
        if (isn(p_sum, C_CONNECTION) || isn(p_sum, C_PROXY) || isn(p_sum, C_KEEPALIVE) ||
            isn(p_sum, C_TRANSFER) || isn(p_sum, C_UPGRADE)) begin
          m_new[B_BAD] = 1'b1;
        end else if (isn(p_sum, C_TE) && !(p_sum.value_is8 && p_sum.trailers)) begin
          m_new[B_BAD] = 1'b1;
        end else begin
          cls = CLS_REGULAR;
          if (isn(p_sum, C_CLEN)) begin
            clen = p_sum.digits;
            clv = 1'b1;
          end
        end
      end
    end
  end

  // forwarding register for back-to-back markers on the same slot
  logic w_valid;
  logic [SW-1:0] w_idx;
  mask_t w_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_valid <= '0;
      p_valid <= 1'b0;
      m_axis_tvalid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      w_valid <= p_adv;
      if (p_adv) begin
        mem[p_idx] <= m_new;
        mem_valid[p_idx] <= 1'b1;
        w_idx <= p_idx;
        w_data <= m_new;
        m_axis_tvalid <= 1'b1;
        m_axis_tuser[0] <= p_eob;
        m_axis_tdata <= {6'd0,
                         p_eob && (m_cur[2:0] != 3'b111),
                         p_eob && (m_cur[2:0] == 3'b111) && !m_cur[B_BAD],
                         clv, clen, qp, plen,
                         p_eob ? m_cur[B_BAD] : m_new[B_BAD],
                         cls, p_slot};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (take) begin
        p_valid <= op == OP_EOF || op == OP_EOB;
        p_eob <= op == OP_EOB;
        p_idx <= sidx;
        p_slot <= slot_fold;
        p_sum <= summary;
        if (p_adv && p_idx == sidx)
          rd_data <= m_new;
        else if (w_valid && w_idx == sidx)
          rd_data <= w_data;
        else
          rd_data <= mem_valid[sidx] ? mem[sidx] : '0;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
    end
  end

  // the read register above is also updated for same-slot writes landing now
  // (reads are issued only with a new transaction, so a stale read needs the
  // in-flight write forwarded; p_valid writes are covered by the first arm)

endmodule

### rtl/h2hv_field_scan.sv
// Per-byte field scanner: name matching, value checks, path split and content-length digits.
// Depends on h2hv_pkg; emits a field summary on end of field or end of block.
module h2hv_field_scan import h2hv_pkg::*; #(
  parameter int MAX_VALUE_LEN = MaxValueLenDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic take,
  input  logic [1:0] op,
  input  logic [7:0] data_byte,
  output field_sum_t summary
);

  localparam int VW = $clog2(MAX_VALUE_LEN + 1);

  logic [4:0] name_length;
  logic [CandCount-1:0] cands;
  logic name_bad, colon, value_bad, last_blank, trailers, question, stopped;
  logic [VW-1:0] value_length, qpos;
  logic [31:0] digits;

  logic [35:0] prod;
  logic [VW-1:0] plen;
  logic is_colon, tok, blank;
  logic [CandCount-1:0] cand_hit;

  always_comb begin
    is_colon = data_byte == 8'h3A;
    tok = TokenMap[data_byte];
    blank = data_byte == 8'h20 || data_byte == 8'h09;
    for (int c = 0; c < CandCount; c++)
      cand_hit[c] = name_length < cand_len(c) && cand_char(c, name_length) == data_byte;
    prod = {4'd0, digits} * 36'd10 + {32'd0, data_byte[3:0]};
    plen = question ? qpos : value_length;
  end

  always_comb begin
    summary.name_length = name_length;
    summary.cands = cands;
    summary.name_bad = name_bad;
    summary.colon = colon;
    summary.value_empty = value_length == '0;
    summary.value_is8 = value_length == VW'(8);
    summary.value_bad = value_bad;
    summary.last_blank = last_blank;
    summary.trailers = trailers;
    summary.path_len = (32'(plen) > 32'h3FFF) ? 14'h3FFF : 14'(plen);
    summary.question = question;
    summary.digits = digits;
  end

  always_ff @(posedge clk) begin
    if (rst || (take && (op == OP_EOF || op == OP_EOB))) begin
      name_length <= '0;
      cands <= '1;
      name_bad <= 1'b0;
      colon <= 1'b0;
      value_length <= '0;
      value_bad <= 1'b0;
      last_blank <= 1'b0;
      trailers <= 1'b1;
      qpos <= '0;
      question <= 1'b0;
      digits <= '0;
      stopped <= 1'b0;
    end else if (take && op == OP_NAME) begin
      if (is_colon ? (name_length != '0) : !tok)
        name_bad <= 1'b1;
      if (name_length == '0)
        colon <= is_colon;
      cands <= cands & cand_hit;
      if (name_length < NameLenMax)
        name_length <= name_length + 5'd1;
    end else if (take && op == OP_VALUE) begin
      if (data_byte == 8'h00 || data_byte == 8'h0A || data_byte == 8'h0D ||
          (value_length == '0 && blank))
        value_bad <= 1'b1;
      last_blank <= blank;
      if (value_length >= VW'(8) || trailers_char(value_length[2:0]) != data_byte)
        trailers <= 1'b0;
      if (!question && data_byte == 8'h3F) begin
        question <= 1'b1;
        qpos <= value_length;
      end
      if (!stopped) begin
        if (data_byte >= 8'h30 && data_byte <= 8'h39)
          digits <= (prod[35:32] != 4'd0) ? 32'hFFFFFFFF : prod[31:0];
        else
          stopped <= 1'b1;
      end
      if (32'(value_length) < MAX_VALUE_LEN)
        value_length <= value_length + VW'(1);
    end
  end

endmodule
